// ===== hw/rtl/asps_pkg.sv =====
// ============================================================================
// asps_pkg: shared types for the active slot priority sorter
// Entry layout of the ordered list and the request bundle for the list RAM.
// ============================================================================
`default_nettype none

package asps_pkg;

   localparam int LIST_DEPTH = 64;
   localparam int ADDR_W     = 6;
   localparam int CNT_W      = 7;
   localparam int PRIO_W     = 16;

   typedef struct packed {
      logic [ADDR_W-1:0]        index;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } list_req_type;

endpackage

`default_nettype wire

// ===== hw/rtl/active_slot_priority_sorter.sv =====
// ============================================================================
// active_slot_priority_sorter: stable descending priority sort of slots
// Loads a slot table one beat at a time, keeps the active slots in an ordered
// list by insertion, and drains the list in priority order after the last slot.
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  req     | in        | req_valid/req_stall | active, priority_req, last_slot
//  rsp     | out       | rsp_valid/rsp_stall | slot_index, slot_priority,
//          |           |                     | none_active, overflow, last_result
//
//  Inactive or dropped slot: handled in S_IDLE alone.
//  Active slot: one S_READ/S_COMPARE step per entry of lower priority it moves
//  past, plus one whose compare fails unless it ends at the head of the list
//  (always so for an empty list, which goes straight to S_PLACE). Each step
//  is a read of the list RAM and a compare/write via the one signed comparator.
//  Drain: S_FINISH after the last slot, then S_FETCH, S_LOAD and S_SEND per
//  result beat, S_SEND holding while rsp_stall is high; an empty table's
//  single beat comes from S_FINISH. req_stall stays high until the drain is done.
//  Synchronous reset clears all counters; list contents need no clearing.
//
`default_nettype none

module active_slot_priority_sorter
   import asps_pkg::*;
#(
   parameter int MAX_SLOTS = 64
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   // slot beats in
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic                req_active,
   input  wire logic signed [15:0]  req_priority_req,
   input  wire logic                req_last_slot,
   // ordered result beats out
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [5:0]          rsp_slot_index,
   output      logic signed [15:0]  rsp_slot_priority,
   output      logic                rsp_none_active,
   output      logic                rsp_overflow,
   output      logic                rsp_last_result
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_COMPARE,
      S_PLACE,
      S_FINISH,
      S_FETCH,
      S_LOAD,
      S_SEND
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  load_pos_ff;   // next slot index of the table
   logic [CNT_W-1:0]  count_ff;      // active entries in the list
   logic              ovf_ff;        // a slot was dropped in this table
   logic              last_ff;       // current beat closes the table
   logic [ADDR_W-1:0] ins_pos_ff;    // hole position during insertion
   logic [ADDR_W-1:0] out_k_ff;      // drain read pointer
   entry_type         new_entry_ff;

   logic              rsp_valid_ff;
   logic [5:0]        rsp_slot_index_ff;
   logic signed [15:0] rsp_slot_priority_ff;
   logic              rsp_none_active_ff;
   logic              rsp_overflow_ff;
   logic              rsp_last_result_ff;

   list_req_type      list_req;
   entry_type         rd_data;
   logic              move_down;

   asps_list_ram u_list (
      .clock   (clock),
      .req     (list_req),
      .rd_data (rd_data)
   );

   // The one comparator: does the stored entry rank below the new slot?
   // Strict less-than keeps equal priorities in arrival order.
   assign move_down = (rd_data.prio < new_entry_ff.prio);

   always_comb begin
      list_req = '0;
      case (state_ff)
         S_READ: begin
            list_req.rd_en   = 1'b1;
            list_req.rd_addr = ins_pos_ff - ADDR_W'(1);
         end
         S_COMPARE: begin
            // shift the lower entry one place down, opening the hole above
            list_req.wr_en   = move_down;
            list_req.wr_addr = ins_pos_ff;
            list_req.wr_data = rd_data;
         end
         S_PLACE: begin
            list_req.wr_en   = 1'b1;
            list_req.wr_addr = ins_pos_ff;
            list_req.wr_data = new_entry_ff;
         end
         S_FETCH: begin
            list_req.rd_en   = 1'b1;
            list_req.rd_addr = out_k_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_pos_ff  <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  last_ff <= req_last_slot;
                  if (load_pos_ff < CNT_W'(MAX_SLOTS)) begin
                     load_pos_ff <= load_pos_ff + CNT_W'(1);
                     if (req_active) begin
                        new_entry_ff.index <= load_pos_ff[ADDR_W-1:0];
                        new_entry_ff.prio  <= req_priority_req;
                        ins_pos_ff         <= count_ff[ADDR_W-1:0];
                        state_ff <= (count_ff == '0) ? S_PLACE : S_READ;
                     end else begin
                        state_ff <= req_last_slot ? S_FINISH : S_IDLE;
                     end
                  end else begin
                     ovf_ff   <= 1'b1;
                     state_ff <= req_last_slot ? S_FINISH : S_IDLE;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_COMPARE;
            end
            S_COMPARE: begin
               if (move_down) begin
                  ins_pos_ff <= ins_pos_ff - ADDR_W'(1);
                  state_ff   <= (ins_pos_ff == ADDR_W'(1)) ? S_PLACE : S_READ;
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: begin
               count_ff <= count_ff + CNT_W'(1);
               state_ff <= last_ff ? S_FINISH : S_IDLE;
            end
            S_FINISH: begin
               out_k_ff <= '0;
               if (count_ff == '0) begin
                  // empty table: one terminator beat
                  rsp_slot_index_ff    <= '0;
                  rsp_slot_priority_ff <= '0;
                  rsp_none_active_ff   <= 1'b1;
                  rsp_overflow_ff      <= ovf_ff;
                  rsp_last_result_ff   <= 1'b1;
                  rsp_valid_ff         <= 1'b1;
                  state_ff             <= S_SEND;
               end else begin
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               rsp_slot_index_ff    <= rd_data.index;
               rsp_slot_priority_ff <= rd_data.prio;
               rsp_none_active_ff   <= 1'b0;
               rsp_overflow_ff      <= ovf_ff;
               rsp_last_result_ff   <= ({1'b0, out_k_ff} + CNT_W'(1)) == count_ff;
               rsp_valid_ff         <= 1'b1;
               state_ff             <= S_SEND;
            end
            S_SEND: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_result_ff) begin
                     // table done: start a fresh one
                     count_ff    <= '0;
                     load_pos_ff <= '0;
                     ovf_ff      <= 1'b0;
                     state_ff    <= S_IDLE;
                  end else begin
                     out_k_ff <= out_k_ff + ADDR_W'(1);
                     state_ff <= S_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_index    = rsp_slot_index_ff;
   assign rsp_slot_priority = rsp_slot_priority_ff;
   assign rsp_none_active   = rsp_none_active_ff;
   assign rsp_overflow      = rsp_overflow_ff;
   assign rsp_last_result   = rsp_last_result_ff;

`ifndef ASSERT_OFF
   a_count_le_pos: assert property (@(posedge clock) disable iff (reset)
      count_ff <= load_pos_ff)
      else $error("active count exceeds load position");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      load_pos_ff <= CNT_W'(MAX_SLOTS))
      else $error("load position beyond slot limit");

   a_hole_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_COMPARE || state_ff == S_PLACE)
      |-> ({1'b0, ins_pos_ff} <= count_ff))
      else $error("insertion position outside list");

   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_active |-> rsp_last_result)
      else $error("empty-table beat not marked last");

   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_result
      |=> (count_ff == '0) && (load_pos_ff == '0) && !ovf_ff)
      else $error("table state not cleared after final beat");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/asps_list_ram.sv =====
// ============================================================================
// asps_list_ram: ordered list storage
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module asps_list_ram
   import asps_pkg::*;
(
   input  wire logic         clock,
   input  wire list_req_type req,
   output entry_type         rd_data
);

   entry_type mem [LIST_DEPTH];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data <= mem[req.rd_addr];
      end
   end

endmodule

`default_nettype wire
